/* design/mspd_pkg.sv */
// Package for the motor speed PID block: types, register indexes, sequencer states.
// No dependencies.
package mspd_pkg;

   localparam int unsigned CsrCount = 8;

   typedef enum logic [2:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_GAIN_FF    = 3'd3,
      CSR_INT_BOUND  = 3'd4,
      CSR_STALL      = 3'd5,
      CSR_NOLOAD     = 3'd6,
      CSR_SPEED_LIM  = 3'd7
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_COMPUTE = 1'b0,
      OP_CLEAR   = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ERR,
      ST_PTERM,
      ST_FTERM,
      ST_DDIV_START,
      ST_DDIV_WAIT,
      ST_DTERM,
      ST_IMUL,
      ST_IACC,
      ST_ITERM,
      ST_SUM,
      ST_RDIV_START,
      ST_RDIV_WAIT,
      ST_CURVE,
      ST_CEIL_MUL,
      ST_CEIL,
      ST_OUT
   } state_type;

   // Divider command and status between the sequencer and the divider.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_sts_type;

   // Saturate a 66-bit signed value to 32-bit signed.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      hi = 66'sd2147483647;
      lo = -66'sd2147483648;
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Truncating (toward zero) divide by 65536 of a signed 66-bit value.
   function automatic logic signed [65:0] qshift(input logic signed [65:0] v);
      logic signed [65:0] adj;
      adj = v[65] ? (v + 66'sd65535) : v;
      return adj >>> 16;
   endfunction

endpackage

/* design/mspd_if.sv */
// Valid/ready channel interfaces for the motor speed PID block.
// Depends on nothing.
interface mspd_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] setpoint;
   logic signed [31:0] measured_speed;
   logic        [30:0] time_step;
   modport source (output valid, op, setpoint, measured_speed, time_step, input ready);
   modport sink   (input valid, op, setpoint, measured_speed, time_step, output ready);
endinterface

interface mspd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive_current;
   modport source (output valid, drive_current, input ready);
   modport sink   (input valid, drive_current, output ready);
endinterface

interface mspd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [30:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/mspd_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, unsigned 64 / 32.
// Depends on mspd_pkg.
module mspd_div
   import mspd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic [63:0] quot_ff, quot_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   // One shift and compare-subtract per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quot_ff[63]};
      if (cmd.start) begin
         quot_in = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = trial - {1'b0, dvs_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quot_ff;

endmodule

/* design/mspd_csr.sv */
// Configuration register file for the motor speed PID block.
// Depends on mspd_pkg and mspd_if.
module mspd_csr
   import mspd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mspd_csr_if.sink    csr,
   output logic [30:0] regs [CsrCount]
);

   logic [30:0] regs_ff [CsrCount];

   assign csr.ready = 1'b1;

   // Each beat writes one register; the 3-bit index covers all eight registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CsrCount; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (csr.valid) begin
         regs_ff[csr.index] <= csr.data;
      end
   end

   assign regs = regs_ff;

endmodule

/* design/motor_speed_pid_dynamic_limit.sv */
// PID speed controller with derivative on measurement and a speed-dependent current
// ceiling. One item is taken at a time. A compute item skips the speed ratio when the
// ceiling needs none (speed limit zero, speed at or above the limit, or an obstacle).
// Each compute item passes through the shared one-bit-per-cycle divider for the
// derivative, and again for the speed ratio where needed; every product uses the shared
// 33x33 multiplier. A clear item's result is valid the cycle after it is accepted. The
// result sits in an output register, and the block is ready again the cycle after it is
// taken. Configuration is written through the csr channel, which is always ready.
module motor_speed_pid_dynamic_limit
   import mspd_pkg::*;
#(
   parameter int OUT_MAX   = 655360,
   parameter int OUT_MIN   = -655360,
   parameter int CURVE_EXP = 1
) (
   input logic      clock,
   input logic      reset,
   mspd_req_if.sink req,
   mspd_rsp_if.source rsp,
   mspd_csr_if.sink csr
);

   logic [30:0] regs [CsrCount];
   div_cmd_type div_cmd;
   div_sts_type div_sts;

   mspd_csr u_csr (.clock, .reset, .csr, .regs);
   mspd_div u_div (.clock, .reset, .cmd(div_cmd), .sts(div_sts));

   state_type state_ff, state_in;
   logic signed [31:0] tgt_ff, meas_ff, err_ff, acc_ff, integ_ff, last_ff, out_ff;
   logic signed [31:0] dyn_ff, curve_ff, ratio_ff;
   logic signed [65:0] sum_ff;
   logic signed [65:0] inc_ff;
   logic [30:0] dt_ff;
   logic        neg_ff;
   logic [2:0]  k_ff;
   logic        rsp_valid_ff;
   logic        curve_path_ff;

   // Shared multiplier operands.
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod;
   logic signed [65:0] prod_q;

   logic [31:0] mag;
   logic [31:0] abs_err;
   logic [31:0] sl;
   logic signed [32:0] diff_d;
   logic [32:0] abs_d;
   logic        obstacle;
   logic signed [32:0] lim_i;
   logic signed [33:0] ceil_curve;
   logic signed [31:0] ceil_lim;
   logic signed [31:0] ceil_cap;

   assign sl      = {1'b0, regs[CSR_SPEED_LIM]};
   assign mag     = meas_ff[31] ? (~meas_ff + 32'd1) : meas_ff;
   assign abs_err = err_ff[31] ? (~err_ff + 32'd1) : err_ff;
   assign diff_d  = {last_ff[31], last_ff} - {meas_ff[31], meas_ff};
   assign abs_d   = diff_d[32] ? (~diff_d + 33'd1) : diff_d;
   assign obstacle = ({3'b0, mag, 1'b0} + {5'b0, mag, 3'b0} < {4'b0, sl}) &&
                     ({3'b0, abs_err, 1'b0} + {5'b0, abs_err, 3'b0} >
                      {3'b0, sl, 1'b0} + {4'b0, sl});
   assign lim_i   = {2'b0, regs[CSR_INT_BOUND]};

   // Ceiling: curve path result or the value picked in the sum step, capped at OUT_MAX.
   assign ceil_curve = {3'b0, regs[CSR_STALL]} - {{2{acc_ff[31]}}, acc_ff};
   assign ceil_lim   = curve_path_ff ? ceil_curve[31:0] : dyn_ff;
   assign ceil_cap   = (ceil_lim > 32'(OUT_MAX)) ? 32'(OUT_MAX) : ceil_lim;

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PTERM:   begin mul_a = {2'b0, regs[CSR_GAIN_P]};  mul_b = {err_ff[31], err_ff}; end
         ST_FTERM:   begin mul_a = {2'b0, regs[CSR_GAIN_FF]}; mul_b = {tgt_ff[31], tgt_ff}; end
         ST_DTERM:   begin mul_a = {2'b0, regs[CSR_GAIN_D]};  mul_b = {acc_ff[31], acc_ff}; end
         ST_IMUL:    begin mul_a = {2'b0, dt_ff};            mul_b = {err_ff[31], err_ff}; end
         ST_ITERM:   begin mul_a = {2'b0, regs[CSR_GAIN_I]};  mul_b = {integ_ff[31], integ_ff}; end
         ST_CURVE:   begin mul_a = {curve_ff[31], curve_ff}; mul_b = {ratio_ff[31], ratio_ff}; end
         ST_CEIL_MUL: begin
            mul_a = {2'b0, regs[CSR_STALL]} - {2'b0, regs[CSR_NOLOAD]};
            mul_b = {curve_ff[31], curve_ff};
         end
         default: ;
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign prod_q = qshift(prod);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid && req.ready) begin
            state_in = (req.op == OP_CLEAR) ? ST_OUT : ST_ERR;
         end
         ST_ERR:        state_in = ST_PTERM;
         ST_PTERM:      state_in = ST_FTERM;
         ST_FTERM:      state_in = ST_DDIV_START;
         ST_DDIV_START: state_in = ST_DDIV_WAIT;
         ST_DDIV_WAIT:  if (div_sts.done) state_in = ST_DTERM;
         ST_DTERM:      state_in = ST_IMUL;
         ST_IMUL:       state_in = ST_IACC;
         ST_IACC:       state_in = ST_ITERM;
         ST_ITERM:      state_in = ST_SUM;
         ST_SUM: begin
            if (sl == '0 || {1'b0, mag} >= {1'b0, sl} || obstacle) state_in = ST_CEIL;
            else state_in = ST_RDIV_START;
         end
         ST_RDIV_START: state_in = ST_RDIV_WAIT;
         ST_RDIV_WAIT:  if (div_sts.done) state_in = ST_CURVE;
         ST_CURVE:      if (k_ff >= 3'(CURVE_EXP)) state_in = ST_CEIL_MUL;
         ST_CEIL_MUL:   state_in = ST_CEIL;
         ST_CEIL:       state_in = ST_OUT;
         ST_OUT:        if (rsp.ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Divider commands.
   always_comb begin
      div_cmd.start    = 1'b0;
      div_cmd.dividend = '0;
      div_cmd.divisor  = '0;
      case (state_ff)
         ST_DDIV_START: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = {15'b0, abs_d, 16'b0};
            div_cmd.divisor  = {1'b0, dt_ff};
         end
         ST_RDIV_START: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = {16'b0, mag, 16'b0};
            div_cmd.divisor  = sl;
         end
         default: ;
      endcase
   end

   // Datapath registers. A zero time step is taken as one LSB when captured.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         last_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               tgt_ff  <= req.setpoint;
               meas_ff <= req.measured_speed;
               dt_ff   <= (req.time_step == '0) ? 31'd1 : req.time_step;
               if (req.valid && req.op == OP_CLEAR) begin
                  out_ff   <= '0;
                  integ_ff <= '0;
                  last_ff  <= '0;
               end
            end
            ST_ERR: err_ff <= sat32(66'(tgt_ff) - 66'(meas_ff));
            ST_PTERM: sum_ff <= 66'(sat32(prod_q));
            ST_FTERM: sum_ff <= sum_ff + 66'(sat32(prod_q));
            ST_DDIV_START: neg_ff <= diff_d[32];
            ST_DDIV_WAIT: if (div_sts.done) begin
               acc_ff <= sat32(neg_ff ? -$signed({2'b0, div_sts.quotient})
                                      : $signed({2'b0, div_sts.quotient}));
            end
            ST_DTERM: sum_ff <= sum_ff + 66'(sat32(prod_q));
            // The integral step is kept at full width until it is clamped.
            ST_IMUL: inc_ff <= prod_q;
            ST_IACC: begin
               if (66'(integ_ff) + inc_ff > 66'(lim_i)) integ_ff <= lim_i[31:0];
               else if (66'(integ_ff) + inc_ff < -66'(lim_i)) integ_ff <= -lim_i[31:0];
               else integ_ff <= integ_ff + inc_ff[31:0];
            end
            ST_ITERM: sum_ff <= 66'(sat32(sum_ff + 66'(sat32(prod_q))));
            ST_SUM: begin
               last_ff <= meas_ff;
               if (sl == '0) dyn_ff <= 32'(OUT_MAX);
               else if (obstacle) dyn_ff <= {1'b0, regs[CSR_STALL]};
               else dyn_ff <= {1'b0, regs[CSR_NOLOAD]};
               k_ff <= 3'd1;
            end
            ST_RDIV_WAIT: if (div_sts.done) begin
               ratio_ff <= div_sts.quotient[31:0];
               curve_ff <= div_sts.quotient[31:0];
            end
            ST_CURVE: if (k_ff < 3'(CURVE_EXP)) begin
               curve_ff <= prod_q[31:0];
               k_ff     <= k_ff + 3'd1;
            end
            ST_CEIL_MUL: acc_ff <= prod_q[31:0];
            ST_CEIL: begin
               if ($signed(sum_ff[31:0]) > ceil_cap) out_ff <= ceil_cap;
               else if ($signed(sum_ff[31:0]) < 32'(OUT_MIN)) out_ff <= 32'(OUT_MIN);
               else out_ff <= sum_ff[31:0];
            end
            default: ;
         endcase
      end
   end

   // Remember whether the ceiling comes from the speed curve.
   always_ff @(posedge clock) begin
      if (reset) curve_path_ff <= 1'b0;
      else if (state_ff == ST_SUM) curve_path_ff <= (state_in == ST_RDIV_START);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_in == ST_OUT);
      end
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff && state_ff == ST_OUT;
   assign rsp.drive_current = out_ff;

endmodule

/* design/mspd_chk.sv */
// Port-level checker for the motor speed PID block, with its bind.
// Depends on mspd_if (through the bound top level's ports).
module mspd_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] rsp_data
);
   // Never ready for input while a result waits.
   a_excl: assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("input ready while result pending");
   // Result holds while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   // An accepted input drops ready next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after accept");
endmodule

bind motor_speed_pid_dynamic_limit mspd_chk u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_data(rsp.drive_current)
);
